// ===== src/color_blob_bounding_box_macros.svh =====
`ifndef COLOR_BLOB_BOUNDING_BOX_MACROS_SVH
`define COLOR_BLOB_BOUNDING_BOX_MACROS_SVH

// same-cycle implication on the block clock
`define CBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the block clock
`define CBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cbb_pkg.sv =====
package cbb_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned LIM_W   = 9;
  localparam int unsigned LSQ_W   = 2 * LIM_W;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned EDGE_W  = 16;
  localparam int unsigned BOX_W   = 12;
  localparam int unsigned SCALE_W = 8;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_CNT_W = 3;

  localparam logic [IDX_W-1:0] REG_TARGET_RED     = 3'd0;
  localparam logic [IDX_W-1:0] REG_TARGET_GREEN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_BLUE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DISTANCE_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = 3'd4;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd5;

  typedef struct packed {
    logic [PIX_W-1:0] target_red;
    logic [PIX_W-1:0] target_green;
    logic [PIX_W-1:0] target_blue;
    logic [LSQ_W-1:0] limit_sq;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] top;
    logic [EDGE_W-1:0] bottom;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } frame_rec_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               empty;
    logic               full;
  } q_status_t;

endpackage

// ===== src/cbb_front.sv =====
module cbb_front #(
  parameter int unsigned MAX_DIM = cbb_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cbb_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cbb_pkg::PIX_W-1:0]  red,
  input  logic [cbb_pkg::PIX_W-1:0]  green,
  input  logic [cbb_pkg::PIX_W-1:0]  blue,
  input  cbb_pkg::q_status_t         q_stat,
  output logic                       push,
  output cbb_pkg::frame_rec_t        rec
);
  import cbb_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned CMP_W = ((CW > DIM_W) ? CW : DIM_W) + 1;

  logic [CW-1:0] col, row;
  logic [CW-1:0] left, right, top, bottom;
  logic          any_hit;

  logic              a_valid, a_last, a_color_ok;
  logic [DIST_W-1:0] a_dist2;
  logic [CW-1:0]     a_col, a_row;

  logic              accept;
  logic [Q_CNT_W-1:0] occ;
  logic [CMP_W-1:0]  col_inc, row_inc;
  logic              end_col, end_row;
  logic [PIX_W-1:0]  d_r, d_g, d_b;
  logic [2*PIX_W-1:0] sq_r, sq_g, sq_b;
  logic [DIST_W-1:0] dist2;
  logic              color_ok, hit;
  logic [CW-1:0]     left_next, right_next, top_next, bottom_next;
  logic              any_hit_next;

  // room for this beat and any frame end already in flight
  assign occ      = q_stat.count + Q_CNT_W'(a_valid && a_last);
  assign in_ready = occ < Q_CNT_W'(Q_DEPTH);
  assign accept   = in_valid && in_ready;

  assign col_inc = CMP_W'(col) + CMP_W'(1);
  assign row_inc = CMP_W'(row) + CMP_W'(1);
  assign end_col = col_inc >= CMP_W'(cfg.width);
  assign end_row = row_inc >= CMP_W'(cfg.height);

  assign d_r  = (red > cfg.target_red) ? red - cfg.target_red : cfg.target_red - red;
  assign d_g  = (green > cfg.target_green) ? green - cfg.target_green
                                           : cfg.target_green - green;
  assign d_b  = (blue > cfg.target_blue) ? blue - cfg.target_blue : cfg.target_blue - blue;
  assign sq_r = d_r * d_r;
  assign sq_g = d_g * d_g;
  assign sq_b = d_b * d_b;
  assign dist2 = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  assign color_ok = ({1'b0, blue} > {green, 1'b0}) && ({1'b0, blue} > {red, 1'b0});

  assign hit = a_valid && a_color_ok && (DIST_W'(cfg.limit_sq) > a_dist2);

  always_comb begin
    any_hit_next = any_hit || hit;
    left_next    = left;
    right_next   = right;
    top_next     = top;
    bottom_next  = bottom;
    if (hit && !any_hit) begin
      left_next   = a_col;
      right_next  = a_col;
      top_next    = a_row;
      bottom_next = a_row;
    end else if (hit) begin
      if (a_col < left)   left_next   = a_col;
      if (a_col > right)  right_next  = a_col;
      if (a_row < top)    top_next    = a_row;
      if (a_row > bottom) bottom_next = a_row;
    end
  end

  assign push       = a_valid && a_last;
  assign rec.found  = any_hit_next;
  assign rec.left   = EDGE_W'(left_next);
  assign rec.right  = EDGE_W'(right_next);
  assign rec.top    = EDGE_W'(top_next);
  assign rec.bottom = EDGE_W'(bottom_next);
  assign rec.width  = cfg.width;
  assign rec.height = cfg.height;

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        if (end_col) begin
          col <= '0;
          row <= end_row ? '0 : row_inc[CW-1:0];
        end else begin
          col <= col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_dist2    <= dist2;
      a_color_ok <= color_ok;
      a_col      <= col;
      a_row      <= row;
      a_last     <= end_col && end_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_hit <= 1'b0;
      left    <= '0;
      right   <= '0;
      top     <= '0;
      bottom  <= '0;
    end else if (push) begin
      any_hit <= 1'b0;
      left    <= '0;
      right   <= '0;
      top     <= '0;
      bottom  <= '0;
    end else begin
      any_hit <= any_hit_next;
      left    <= left_next;
      right   <= right_next;
      top     <= top_next;
      bottom  <= bottom_next;
    end
  end

endmodule

// ===== src/cbb_queue.sv =====
module cbb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cbb_pkg::frame_rec_t din,
  input  logic                pop,
  output cbb_pkg::frame_rec_t dout,
  output cbb_pkg::q_status_t  stat
);
  import cbb_pkg::*;

  frame_rec_t         slots [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign dout       = slots[rd_ptr];
  assign stat.count = count;
  assign stat.empty = count == '0;
  assign stat.full  = count == Q_CNT_W'(Q_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/cbb_back.sv =====
module cbb_back (
  input  logic                              clk,
  input  logic                              rst,
  input  cbb_pkg::frame_rec_t               q_dout,
  input  cbb_pkg::q_status_t                q_stat,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cbb_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import cbb_pkg::*;

  localparam int unsigned SUM_W = EDGE_W + 1;
  localparam int unsigned NUM_W = SUM_W + SCALE_W;
  localparam int unsigned DEN_W = DIM_W + 1;
  localparam int unsigned PAD_W = OUT_TDATA_W - (2 * SCALE_W + 1 + 4 * BOX_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SAT  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]         state;
  frame_rec_t         rec;
  logic               op_height;
  logic [NUM_W-1:0]   rem;
  logic [DEN_W-1:0]   den;
  logic [2:0]         step;
  logic [SCALE_W-1:0] quo, centre_q, height_q;

  logic [SUM_W-1:0]   sum;
  logic [DEN_W-1:0]   den_load;
  logic [NUM_W-1:0]   shifted, trial;
  logic               ge, fin;
  logic [SCALE_W-1:0] quo_next, fin_q;

  assign pop = (state == ST_IDLE) && !q_stat.empty;

  always_comb begin
    if (op_height) begin
      sum      = SUM_W'(rec.bottom) - SUM_W'(rec.top);
      den_load = DEN_W'(rec.height);
    end else begin
      sum      = SUM_W'(rec.left) + SUM_W'(rec.right);
      den_load = {rec.width, 1'b0};
    end
  end

  // restoring divide, one quotient bit per cycle
  assign shifted  = (state == ST_SAT) ? (NUM_W'(den) << SCALE_W) : (NUM_W'(den) << step);
  assign ge       = rem >= shifted;
  assign trial    = rem - shifted;
  assign quo_next = ge ? (quo | (SCALE_W'(1) << step)) : quo;

  always_comb begin
    fin   = 1'b0;
    fin_q = quo_next;
    case (state)
      ST_SAT: begin
        fin   = ge;
        fin_q = '1;
      end
      ST_DIV: begin
        fin = step == '0;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_SAT;
        end
        ST_SAT: begin
          if (fin) state <= op_height ? ST_OUT : ST_LOAD;
          else     state <= ST_DIV;
        end
        ST_DIV: begin
          if (fin) state <= op_height ? ST_OUT : ST_LOAD;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop) begin
          rec       <= q_dout;
          op_height <= 1'b0;
        end
      end
      ST_LOAD: begin
        rem <= (NUM_W'(sum) << SCALE_W) - NUM_W'(sum);
        den <= den_load;
      end
      ST_SAT: begin
        step <= 3'(SCALE_W - 1);
        quo  <= '0;
        if (fin) begin
          if (op_height) height_q <= fin_q;
          else           centre_q <= fin_q;
          op_height <= 1'b1;
        end
      end
      ST_DIV: begin
        if (ge) rem <= trial;
        quo  <= quo_next;
        step <= step - 3'd1;
        if (fin) begin
          if (op_height) height_q <= fin_q;
          else           centre_q <= fin_q;
          op_height <= 1'b1;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {{PAD_W{1'b0}}, rec.bottom[BOX_W-1:0], rec.top[BOX_W-1:0],
                      rec.right[BOX_W-1:0], rec.left[BOX_W-1:0], rec.found,
                      height_q, centre_q};
        end
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

endmodule

// ===== src/color_blob_bounding_box.sv =====
// throughput: one pixel beat per cycle while the frame queue has room; each beat is
// registered with its colour test and distance, then updates the box registers
// result: scaled by the shared restoring divider (8 steps unless the quotient saturates,
// run once for centre and once for height); a four-entry frame queue decouples the
// pixel side, so frames shorter than the back end's per-frame work throttle input; rst
// (synchronous, active high) clears counters, box, queue and output; registers get defaults
`include "color_blob_bounding_box_macros.svh"

module color_blob_bounding_box #(
  parameter int unsigned MAX_DIM = cbb_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [cbb_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // centre_scaled [7:0], height_scaled [15:8], found [16], box_left [28:17],
  // box_right [40:29], box_top [52:41], box_bottom [64:53], zero [71:65]
  output logic [cbb_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_wr_en,
  input  logic [cbb_pkg::IDX_W-1:0]         cfg_index,
  input  logic [cbb_pkg::CFG_W-1:0]         cfg_data
);
  import cbb_pkg::*;

  cfg_t       cfg;
  frame_rec_t push_rec, pop_rec;
  q_status_t  q_stat;
  logic       push, pop;
  logic [LIM_W-1:0] lim;

  logic             out_found;
  logic [BOX_W-1:0] out_left, out_right, out_top, out_bottom;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign lim = cfg_data[LIM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_red   <= 8'd0;
      cfg.target_green <= 8'd60;
      cfg.target_blue  <= 8'd220;
      cfg.limit_sq     <= LSQ_W'(125 * 125);
      cfg.width        <= clamp_dim(CFG_W'(640));
      cfg.height       <= clamp_dim(CFG_W'(480));
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET_RED:     cfg.target_red   <= cfg_data[PIX_W-1:0];
        REG_TARGET_GREEN:   cfg.target_green <= cfg_data[PIX_W-1:0];
        REG_TARGET_BLUE:    cfg.target_blue  <= cfg_data[PIX_W-1:0];
        REG_DISTANCE_LIMIT: cfg.limit_sq     <= lim * lim;
        REG_FRAME_WIDTH:    cfg.width        <= clamp_dim(cfg_data);
        REG_FRAME_HEIGHT:   cfg.height       <= clamp_dim(cfg_data);
        default:            cfg              <= cfg;
      endcase
    end
  end

  cbb_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .red      (s_tdata[7:0]),
    .green    (s_tdata[15:8]),
    .blue     (s_tdata[23:16]),
    .q_stat   (q_stat),
    .push     (push),
    .rec      (push_rec)
  );

  cbb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_rec),
    .pop  (pop),
    .dout (pop_rec),
    .stat (q_stat)
  );

  cbb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_dout   (pop_rec),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  assign out_found  = m_tdata[16];
  assign out_left   = m_tdata[28:17];
  assign out_right  = m_tdata[40:29];
  assign out_top    = m_tdata[52:41];
  assign out_bottom = m_tdata[64:53];

  `CBB_ASSERT_NOW(a_no_overflow, push, !q_stat.full, "frame queue overflow")
  `CBB_ASSERT_NOW(a_full_stalls, q_stat.full, !s_tready, "pixel taken with queue full")
  `CBB_ASSERT_NEXT(a_count_up, push && !pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count off")
  `CBB_ASSERT_NOW(a_empty_zero, m_tvalid && !out_found, m_tdata == '0, "empty frame not zero")
  `CBB_ASSERT_NOW(a_box_order, m_tvalid && out_found, (out_left <= out_right) && (out_top <= out_bottom), "box edges out of order")

endmodule

// ===== dv/color_blob_bounding_box_test.sv =====
`timescale 1ns / 1ps

// one result beat, last field in the lowest bits
typedef struct packed {
  logic [6:0]  pad;
  logic [11:0] box_bottom;
  logic [11:0] box_top;
  logic [11:0] box_right;
  logic [11:0] box_left;
  logic        found;
  logic [7:0]  height_scaled;
  logic [7:0]  centre_scaled;
} box_beat_t;

class blob_box_tracker;
  logic [7:0]  target_red = 8'd0;
  logic [7:0]  target_green = 8'd60;
  logic [7:0]  target_blue = 8'd220;
  logic [8:0]  distance_limit = 9'd125;
  logic [12:0] frame_width = 13'd640;
  logic [12:0] frame_height = 13'd480;

  logic [11:0] column = '0;
  logic [11:0] row = '0;
  logic [11:0] left_edge = '0;
  logic [11:0] right_edge = '0;
  logic [11:0] top_edge = '0;
  logic [11:0] bottom_edge = '0;
  logic        any_hit = 1'b0;

  box_beat_t expected_boxes[$];
  int mismatches = 0;

  function int unsigned dim_of(logic [12:0] v);
    if (v == 0) return 1;
    if (v > cbb_pkg::MAX_DIM_DEF) return cbb_pkg::MAX_DIM_DEF;
    return v;
  endfunction

  function int unsigned sq_diff(int unsigned a, int unsigned b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function int pending();
    return expected_boxes.size();
  endfunction

  function void write_reg(logic [cbb_pkg::IDX_W-1:0] idx, logic [12:0] data);
    case (idx)
      cbb_pkg::REG_TARGET_RED:     target_red = data[7:0];
      cbb_pkg::REG_TARGET_GREEN:   target_green = data[7:0];
      cbb_pkg::REG_TARGET_BLUE:    target_blue = data[7:0];
      cbb_pkg::REG_DISTANCE_LIMIT: distance_limit = data[8:0];
      cbb_pkg::REG_FRAME_WIDTH:    frame_width = data;
      cbb_pkg::REG_FRAME_HEIGHT:   frame_height = data;
      default: ;
    endcase
  endfunction

  function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, dist2, lsq, span, centre, height;
    logic hit;
    box_beat_t res;
    w = dim_of(frame_width);
    h = dim_of(frame_height);
    dist2 = sq_diff(r, target_red) + sq_diff(g, target_green) + sq_diff(b, target_blue);
    lsq = distance_limit;
    lsq = lsq * lsq;
    hit = (dist2 < lsq) && (b > 2 * g) && (b > 2 * r);
    if (hit) begin
      if (!any_hit) begin
        left_edge = column;
        right_edge = column;
        top_edge = row;
        bottom_edge = row;
        any_hit = 1'b1;
      end else begin
        if (column < left_edge) left_edge = column;
        if (column > right_edge) right_edge = column;
        if (row < top_edge) top_edge = row;
        if (row > bottom_edge) bottom_edge = row;
      end
    end
    if (column + 1 >= w) begin
      column = '0;
      if (row + 1 >= h) begin
        res = '0;
        if (any_hit) begin
          span = left_edge;
          span = span + right_edge;
          centre = (span * 255) / (2 * w);
          span = bottom_edge - top_edge;
          height = (span * 255) / h;
          res.centre_scaled = (centre > 255) ? 8'd255 : centre[7:0];
          res.height_scaled = (height > 255) ? 8'd255 : height[7:0];
          res.found = 1'b1;
          res.box_left = left_edge;
          res.box_right = right_edge;
          res.box_top = top_edge;
          res.box_bottom = bottom_edge;
        end
        expected_boxes.push_back(res);
        row = '0;
        any_hit = 1'b0;
        left_edge = '0;
        right_edge = '0;
        top_edge = '0;
        bottom_edge = '0;
      end else begin
        row++;
      end
    end else begin
      column++;
    end
  endfunction

  function void compare(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    end
  endfunction

  function void check_box(logic [cbb_pkg::OUT_TDATA_W-1:0] data);
    box_beat_t got, want;
    got = data;
    if (expected_boxes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t: unexpected result beat %h", $realtime, data);
      return;
    end
    want = expected_boxes.pop_front();
    compare("centre_scaled", want.centre_scaled, got.centre_scaled);
    compare("height_scaled", want.height_scaled, got.height_scaled);
    compare("found", want.found, got.found);
    compare("box_left", want.box_left, got.box_left);
    compare("box_right", want.box_right, got.box_right);
    compare("box_top", want.box_top, got.box_top);
    compare("box_bottom", want.box_bottom, got.box_bottom);
    compare("pad", want.pad, got.pad);
  endfunction
endclass

module color_blob_bounding_box_test;
  import cbb_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cur_red, cur_green, cur_blue, cur_limit;
  logic [12:0] cur_width, cur_height;

  blob_box_tracker boxes;

  color_blob_bounding_box dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("color_blob_bounding_box test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) boxes.check_box(m_tdata);
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_pixel(input int r, input int g, input int b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b[7:0], g[7:0], r[7:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    boxes.take_pixel(r[7:0], g[7:0], b[7:0]);
  endtask

  // hold the pixel side until every box is out and the pipeline is empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (boxes.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input int data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_W-1:0];
    @(posedge clk);
    boxes.write_reg(idx, data[12:0]);
  endtask

  task automatic set_frame(input int w, input int h);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_wr_en <= 1'b0;
    cur_width = w[12:0];
    cur_height = h[12:0];
  endtask

  task automatic apply_settings(input int tr, input int tg, input int tb, input int lim,
                                input int w, input int h);
    cfg_write(REG_TARGET_RED, tr);
    cfg_write(REG_TARGET_GREEN, tg);
    cfg_write(REG_TARGET_BLUE, tb);
    cfg_write(REG_DISTANCE_LIMIT, lim);
    // writes to unmapped indexes must be dropped
    if ($urandom_range(0, 1) == 0) cfg_write(REG_SPARE_A, $urandom_range(0, 8191));
    else cfg_write(REG_SPARE_B, $urandom_range(0, 8191));
    cur_red = tr;
    cur_green = tg;
    cur_blue = tb;
    cur_limit = lim;
    set_frame(w, h);
  endtask

  task automatic pick_settings();
    int tr, tg, tb, lim, w, h;
    if ($urandom_range(0, 3) != 0) begin
      tr = $urandom_range(0, 60);
      tg = $urandom_range(0, 60);
      tb = $urandom_range(130, 255);
    end else begin
      tr = $urandom_range(0, 255);
      tg = $urandom_range(0, 255);
      tb = $urandom_range(0, 255);
    end
    case ($urandom_range(0, 9))
      0: lim = 0;
      1: lim = 442;
      2: lim = $urandom_range(0, 442);
      default: lim = $urandom_range(20, 250);
    endcase
    case ($urandom_range(0, 19))
      0: w = 0;
      1: w = 1;
      default: w = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 19))
      0: h = 0;
      1: h = 1;
      default: h = $urandom_range(1, 8);
    endcase
    apply_settings(tr, tg, tb, lim, w, h);
  endtask

  function automatic int near(int t, int spread);
    int v;
    v = t - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  task automatic send_pixels(input int n);
    int r, g, b, spread, pick;
    spread = (cur_limit / 2 + 1 > 255) ? 255 : cur_limit / 2 + 1;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        r = near(cur_red, spread);
        g = near(cur_green, spread);
        b = near(cur_blue, spread);
      end else if (pick < 18) begin
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end else begin
        r = $urandom_range(0, 1) * 255;
        g = $urandom_range(0, 1) * 255;
        b = $urandom_range(0, 1) * 255;
      end
      send_pixel(r, g, b);
    end
  endtask

  task automatic random_phase(input int sidle, input int ridle, input int budget);
    int sent, n;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    wait_idle();
    pick_settings();
    while (sent < budget) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        pick_settings();
      end
      n = boxes.dim_of(cur_width) * boxes.dim_of(cur_height);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      send_pixels(n);
      sent += n;
    end
  endtask

  initial begin
    boxes = new();
    cur_red = 0;
    cur_green = 60;
    cur_blue = 220;
    cur_limit = 125;
    cur_width = 13'd640;
    cur_height = 13'd480;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 50;
    // reset colour and limit, small frame
    set_frame(3, 2);
    send_pixel(0, 60, 220);
    send_pixel(255, 255, 255);
    send_pixel(0, 0, 255);
    send_pixel(0, 0, 0);
    send_pixel(0, 60, 220);
    send_pixel(10, 10, 10);
    // nothing qualifies
    wait_idle();
    set_frame(2, 1);
    send_pixel(0, 0, 0);
    send_pixel(0, 0, 0);
    // blue exactly twice green or red does not qualify
    wait_idle();
    apply_settings(0, 100, 200, 442, 2, 2);
    send_pixel(0, 100, 200);
    send_pixel(0, 99, 200);
    send_pixel(100, 0, 200);
    send_pixel(255, 255, 255);
    // zero width acts as one, distance must be strictly below the limit
    wait_idle();
    apply_settings(0, 0, 255, 1, 0, 3);
    send_pixel(0, 0, 255);
    send_pixel(0, 0, 254);
    send_pixel(0, 0, 255);
    // zero limit never qualifies
    wait_idle();
    apply_settings(0, 0, 255, 0, 1, 1);
    send_pixel(0, 0, 255);
    // frame cut short by a size change, both scaled values saturate
    wait_idle();
    apply_settings(0, 0, 255, 442, 4, 8);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 255);
    send_pixel(255, 255, 255);
    send_pixel(0, 0, 255);
    repeat (4) send_pixel(255, 0, 0);
    send_pixel(0, 0, 255);
    wait_idle();
    set_frame(1, 1);
    send_pixel(0, 0, 255);

    random_phase(21, 87, 600);
    random_phase(87, 21, 600);
    random_phase(0, 0, 600);

    // oversize width, row ended early by a narrower frame
    wait_idle();
    apply_settings($urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(130, 255),
                   442, 8191, 2);
    send_pixels(48);
    wait_idle();
    set_frame(5, 1);
    send_pixels(2);

    wait_idle();
    if (boxes.mismatches == 0 && boxes.pending() == 0) begin
      $display("color_blob_bounding_box test passed");
    end else begin
      $display("color_blob_bounding_box test failed");
    end
    $finish;
  end
endmodule
